// File: rtl/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int COORD_BITS = 12;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS+1:0] wide_t;
  typedef logic [1:0]            kind_t;
  typedef logic [2:0]            count_t;
  typedef logic [7:0]            rev_t;
  typedef logic [2:0]            reg_idx_t;

  // Sample kinds
  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_MOVE  = 2'd1;
  localparam kind_t KIND_STOP  = 2'd2;
  localparam kind_t KIND_KILL  = 2'd3;

  // Configuration register indexes
  localparam reg_idx_t REG_SWIPE_LENGTH = 3'd0;
  localparam reg_idx_t REG_SWIPE_WIDTH  = 3'd1;
  localparam reg_idx_t REG_SHAPE_WIDTH  = 3'd2;
  localparam reg_idx_t REG_SHAPE_HEIGHT = 3'd3;
  localparam reg_idx_t REG_X_TOL        = 3'd4;
  localparam reg_idx_t REG_Y_TOL        = 3'd5;

  localparam coord_t RST_SWIPE_LENGTH = COORD_BITS'(200);
  localparam coord_t RST_SWIPE_WIDTH  = COORD_BITS'(50);
  localparam coord_t RST_SHAPE_WIDTH  = COORD_BITS'(100);
  localparam coord_t RST_SHAPE_HEIGHT = COORD_BITS'(100);
  localparam coord_t RST_X_TOL        = COORD_BITS'(30);
  localparam coord_t RST_Y_TOL        = COORD_BITS'(30);

  localparam count_t TAP_MAX_SAMPLES  = 3'd5;
  localparam count_t SHAPE_MIN_BEYOND = 3'd4;
  localparam count_t COUNT_MAX        = 3'd7;
  localparam rev_t   REV_MAX          = 8'd255;
  localparam rev_t   Z_MIN_REVERSALS  = 8'd2;

  typedef struct packed {
    coord_t swipe_length;
    coord_t swipe_width_limit;
    coord_t shape_width;
    coord_t shape_height;
    coord_t x_tolerance;
    coord_t y_tolerance;
  } cfg_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t last_x;
    coord_t last_y;
    coord_t x_low;
    coord_t x_high;
    coord_t y_low;
    coord_t y_high;
    logic   moving_right;
    rev_t   rev;
    count_t count;
    logic   live;
    logic   dead;
  } trk_t;

  // Stroke state after reset: everything clear, heading right
  localparam trk_t TRK_RESET = '{moving_right: 1'b1, default: '0};

  typedef struct packed {
    logic   is_live;
    logic   is_dead;
    logic   tap;
    logic   swipe_up;
    logic   swipe_down;
    logic   circle;
    logic   z_shape;
    coord_t start_x;
    coord_t start_y;
    coord_t current_x;
    coord_t current_y;
    rev_t   reversals;
  } res_t;

endpackage

// File: rtl/tgc_if.sv
// Valid/ready channel interfaces for touch samples and gesture results.
`timescale 1ns / 1ps

interface tgc_in_if
  import tgc_pkg::*;
();
  logic   valid;
  logic   ready;
  kind_t  kind;
  coord_t sample_x;
  coord_t sample_y;

  modport source (output valid, kind, sample_x, sample_y, input ready);
  modport sink   (input valid, kind, sample_x, sample_y, output ready);
endinterface

interface tgc_out_if
  import tgc_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   is_live;
  logic   is_dead;
  logic   tap;
  logic   swipe_up;
  logic   swipe_down;
  logic   circle;
  logic   z_shape;
  coord_t start_x;
  coord_t start_y;
  coord_t current_x;
  coord_t current_y;
  rev_t   reversals;

  modport source (output valid, is_live, is_dead, tap, swipe_up, swipe_down, circle,
                  z_shape, start_x, start_y, current_x, current_y, reversals,
                  input ready);
  modport sink   (input valid, is_live, is_dead, tap, swipe_up, swipe_down, circle,
                  z_shape, start_x, start_y, current_x, current_y, reversals,
                  output ready);
endinterface

// File: rtl/tgc_track.sv
// Stroke tracker: points, bounding box, direction, reversal and sample counts.
`timescale 1ns / 1ps

module tgc_track
  import tgc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   acc,
  input  kind_t  kind,
  input  coord_t sample_x,
  input  coord_t sample_y,
  output trk_t   st_r
);

  trk_t st_nxt;

  always_comb begin
    logic rev_hit;
    st_nxt  = st_r;
    rev_hit = 1'b0;
    if (acc) begin
      unique case (kind)
        KIND_START: begin
          st_nxt.first_x      = sample_x;
          st_nxt.first_y      = sample_y;
          st_nxt.second_x     = sample_x;
          st_nxt.second_y     = sample_y;
          st_nxt.last_x       = sample_x;
          st_nxt.last_y       = sample_y;
          st_nxt.x_low        = sample_x;
          st_nxt.x_high       = sample_x;
          st_nxt.y_low        = sample_y;
          st_nxt.y_high       = sample_y;
          st_nxt.count        = 3'd1;
          st_nxt.live         = 1'b1;
          st_nxt.dead         = 1'b0;
          st_nxt.moving_right = 1'b1;
          st_nxt.rev          = '0;
        end
        KIND_MOVE, KIND_STOP: begin
          if (kind == KIND_STOP) begin
            st_nxt.live = 1'b0;
          end
          if (st_r.count == '0) begin
            // no sample held yet: load as a first point, flags kept
            st_nxt.first_x  = sample_x;
            st_nxt.first_y  = sample_y;
            st_nxt.second_x = sample_x;
            st_nxt.second_y = sample_y;
            st_nxt.last_x   = sample_x;
            st_nxt.last_y   = sample_y;
            st_nxt.x_low    = sample_x;
            st_nxt.x_high   = sample_x;
            st_nxt.y_low    = sample_y;
            st_nxt.y_high   = sample_y;
            st_nxt.count    = 3'd1;
          end else begin
            if (sample_x > st_r.last_x) begin
              rev_hit             = !st_r.moving_right;
              st_nxt.moving_right = 1'b1;
            end else if (sample_x < st_r.last_x) begin
              rev_hit             = st_r.moving_right;
              st_nxt.moving_right = 1'b0;
            end
            // a turn counts only once two samples are held
            if (rev_hit && st_r.count > 3'd1 && st_r.rev != REV_MAX) begin
              st_nxt.rev = st_r.rev + 8'd1;
            end
            if (st_r.count == 3'd1) begin
              st_nxt.second_x = sample_x;
              st_nxt.second_y = sample_y;
            end
            st_nxt.last_x = sample_x;
            st_nxt.last_y = sample_y;
            if (sample_x > st_r.x_high) st_nxt.x_high = sample_x;
            if (sample_x < st_r.x_low)  st_nxt.x_low  = sample_x;
            if (sample_y > st_r.y_high) st_nxt.y_high = sample_y;
            if (sample_y < st_r.y_low)  st_nxt.y_low  = sample_y;
            if (st_r.count != COUNT_MAX) begin
              st_nxt.count = st_r.count + 3'd1;
            end
          end
        end
        KIND_KILL: begin
          st_nxt.dead = 1'b1;
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TRK_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_kill_sets_dead: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_KILL |=> st_r.dead)
    else $error("kill item did not set the dead flag");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_START |=> st_r.count == 3'd1 && st_r.live && !st_r.dead &&
      st_r.rev == '0 && st_r.first_x == $past(sample_x) && st_r.first_y == $past(sample_y))
    else $error("start item did not reload the stroke");

  a_box_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.x_low <= st_r.last_x && st_r.last_x <= st_r.x_high &&
    st_r.y_low <= st_r.last_y && st_r.last_y <= st_r.y_high)
    else $error("latest point outside the bounding box");

  a_rev_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count < 3'd2 |-> st_r.rev == '0 || $stable(st_r.rev))
    else $error("reversal counted with fewer than two samples");

endmodule

// File: rtl/tgc_classify.sv
// Gesture tests on the tracked stroke: tap, swipes, circle and Z.
`timescale 1ns / 1ps

module tgc_classify
  import tgc_pkg::*;
(
  input  trk_t st,
  input  cfg_t cfg,
  output res_t res
);

  // target lies within tol of end_v
  function automatic logic near(input wide_t target, input wide_t end_v, input wide_t tol);
    near = (target <= end_v + tol) && (target + tol >= end_v);
  endfunction

  coord_t xext;
  coord_t yext;
  logic   two_plus;
  logic   swipe_ok;
  logic   big;
  wide_t  fx;
  wide_t  fy;
  wide_t  lx;
  wide_t  ly;
  wide_t  xtol;
  wide_t  ytol;
  wide_t  zx;
  wide_t  zy;

  assign xext     = st.x_high - st.x_low;
  assign yext     = st.y_high - st.y_low;
  assign two_plus = st.count >= 3'd2;
  assign swipe_ok = two_plus && yext >= cfg.swipe_length && xext < cfg.swipe_width_limit;
  assign big      = st.count > SHAPE_MIN_BEYOND && xext >= cfg.shape_width &&
                    yext >= cfg.shape_height;

  assign fx   = wide_t'(st.first_x);
  assign fy   = wide_t'(st.first_y);
  assign lx   = wide_t'(st.last_x);
  assign ly   = wide_t'(st.last_y);
  assign xtol = wide_t'(cfg.x_tolerance);
  assign ytol = wide_t'(cfg.y_tolerance);
  assign zx   = fx + wide_t'(cfg.shape_width);
  assign zy   = fy + wide_t'(cfg.shape_height);

  always_comb begin
    res.is_live    = st.live;
    res.is_dead    = st.dead;
    res.tap        = two_plus && st.count <= TAP_MAX_SAMPLES &&
                     st.first_x == st.second_x && st.first_y == st.second_y;
    res.swipe_up   = swipe_ok && st.last_y == st.y_low;
    res.swipe_down = swipe_ok && st.last_y == st.y_high;
    res.circle     = big && near(fx, lx, xtol) && near(fy, ly, ytol);
    res.z_shape    = big && near(zx, lx, xtol) && near(zy, ly, ytol) &&
                     st.rev >= Z_MIN_REVERSALS;
    res.start_x    = st.first_x;
    res.start_y    = st.first_y;
    res.current_x  = st.last_x;
    res.current_y  = st.last_y;
    res.reversals  = st.rev;
  end

endmodule

// File: rtl/touch_gesture_classifier.sv
// Throughput: one item per cycle while the output is not stalled; the stroke state registers take the item,
// the gesture tests run from them into the result register.
// A new item is taken while a result waits, as long as the pending slot can move.
// Reset (synchronous, rst_n low): channels empty, stroke cleared, registers to defaults.
`timescale 1ns / 1ps

module touch_gesture_classifier
  import tgc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  tgc_in_if.sink   in_ch,
  tgc_out_if.source out_ch,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  coord_t   cfg_data
);

  cfg_t cfg_r;
  trk_t st_r;
  res_t cls;
  res_t res_r;
  logic pend_r;
  logic pend_nxt;
  logic out_valid_r;
  logic out_free;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_length      <= RST_SWIPE_LENGTH;
      cfg_r.swipe_width_limit <= RST_SWIPE_WIDTH;
      cfg_r.shape_width       <= RST_SHAPE_WIDTH;
      cfg_r.shape_height      <= RST_SHAPE_HEIGHT;
      cfg_r.x_tolerance       <= RST_X_TOL;
      cfg_r.y_tolerance       <= RST_Y_TOL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWIPE_LENGTH: cfg_r.swipe_length      <= cfg_data;
        REG_SWIPE_WIDTH:  cfg_r.swipe_width_limit <= cfg_data;
        REG_SHAPE_WIDTH:  cfg_r.shape_width       <= cfg_data;
        REG_SHAPE_HEIGHT: cfg_r.shape_height      <= cfg_data;
        REG_X_TOL:        cfg_r.x_tolerance       <= cfg_data;
        REG_Y_TOL:        cfg_r.y_tolerance       <= cfg_data;
        default:          cfg_r                   <= cfg_r;
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !pend_r || out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pend_nxt    = acc || (pend_r && !out_free);

  tgc_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .kind     (in_ch.kind),
    .sample_x (in_ch.sample_x),
    .sample_y (in_ch.sample_y),
    .st_r     (st_r)
  );

  tgc_classify u_classify (
    .st  (st_r),
    .cfg (cfg_r),
    .res (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_free) begin
        out_valid_r <= pend_r;
      end
    end
  end

  // capture the item's result before the state takes the next item
  always_ff @(posedge clk) begin
    if (out_free && pend_r) begin
      res_r <= cls;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.is_live    = res_r.is_live;
  assign out_ch.is_dead    = res_r.is_dead;
  assign out_ch.tap        = res_r.tap;
  assign out_ch.swipe_up   = res_r.swipe_up;
  assign out_ch.swipe_down = res_r.swipe_down;
  assign out_ch.circle     = res_r.circle;
  assign out_ch.z_shape    = res_r.z_shape;
  assign out_ch.start_x    = res_r.start_x;
  assign out_ch.start_y    = res_r.start_y;
  assign out_ch.current_x  = res_r.current_x;
  assign out_ch.current_y  = res_r.current_y;
  assign out_ch.reversals  = res_r.reversals;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !pend_r || out_free)
    else $error("item accepted over a pending result that cannot move");

  a_pend_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_free |=> out_valid_r)
    else $error("pending result lost on its way to the output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

endmodule
